[sv/bdll_pkg.sv]
// Operation and status codes shared by the list manager and its checker.
`default_nettype none
package bdll_pkg;

  localparam logic [3:0] OP_APPEND = 4'd0;
  localparam logic [3:0] OP_INS_BEFORE = 4'd1;
  localparam logic [3:0] OP_INS_AFTER = 4'd2;
  localparam logic [3:0] OP_REMOVE = 4'd3;
  localparam logic [3:0] OP_READ = 4'd4;
  localparam logic [3:0] OP_FIRST = 4'd5;
  localparam logic [3:0] OP_LAST = 4'd6;
  localparam logic [3:0] OP_NEXT = 4'd7;
  localparam logic [3:0] OP_PREV = 4'd8;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD = 2'd3;

  localparam int unsigned CFG_W = 7;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 7'd64;

endpackage
`default_nettype wire

[sv/bounded_doubly_linked_list_top.sv]
// Bounded doubly linked list manager with a free-node stack.
//
// Input channel: one beat carries an operation code, a node position and an
// element value. It is taken when in_valid_i is high and in_stall_o is low.
// Output channel: one beat per input beat carries the status, the node found
// or created, the element read or removed, and the length, empty and full
// flags after the operation; it is taken when out_valid_o is high and
// out_stall_i is low.
// Configuration: cfg_valid_i with cfg_data_i writes the length limit; ready
// is always high. Write it only while the block is idle.
// The result register takes the beat when the working stage commits it, and a
// beat may be accepted in every cycle that in_stall_o is low. The accepting
// edge registers the beat with the element, links and in-use flag of the
// node it names and the node on top of the free stack, taking in any write
// made at that same edge; the commit edge evaluates the operation, writes the
// node state back and registers the result.
// When the receiver stalls, the result register holds its beat, the working
// stage holds its item and in_stall_o rises; nothing is lost.
// Reset clears the list at once: every link is null, no node is in use, the
// free stack holds every node with node 0 on top and the limit is 64.
`default_nettype none
module bounded_doubly_linked_list_top #(
  parameter int unsigned NODES = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [3:0]                  op_i,
  input  wire logic [$clog2(NODES)-1:0]    position_i,
  input  wire logic [ELEM_WIDTH-1:0]       elem_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [1:0]                       status_o,
  output logic [$clog2(NODES)-1:0]         result_position_o,
  output logic [ELEM_WIDTH-1:0]            result_elem_o,
  output logic [$clog2(NODES):0]           length_o,
  output logic                             is_empty_o,
  output logic                             is_full_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bdll_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned MW = (CW > bdll_pkg::CFG_W) ? CW : bdll_pkg::CFG_W;
  localparam logic [CW-1:0] NIL = CW'(NODES);
  localparam logic [MW-1:0] NODES_M = MW'(NODES);

  // Node state. Links carry one extra bit so that NODES stands for null.
  logic [CW-1:0]         next_q [NODES];
  logic [CW-1:0]         prev_q [NODES];
  logic [NODES-1:0]      in_use_q;
  logic [IW-1:0]         free_q [NODES];
  logic [ELEM_WIDTH-1:0] elem_mem [NODES];
  logic [CW-1:0]         free_top_q, free_top_d;
  logic [CW-1:0]         head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]         count_q, count_d;
  logic [bdll_pkg::CFG_W-1:0] max_len_q;

  // Working stage.
  logic                  stg_valid_q;
  logic [3:0]            op_q;
  logic [IW-1:0]         pos_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [ELEM_WIDTH-1:0] rd_elem_q;
  logic [CW-1:0]         nx_q, pr_q;
  logic                  used_q;
  logic [IW-1:0]         new_n_q;

  // Result register.
  logic                  out_valid_q;
  logic [1:0]            status_q, status_d;
  logic [IW-1:0]         rpos_q, rpos_d;
  logic [ELEM_WIDTH-1:0] relem_q, relem_d;
  logic [CW-1:0]         length_q;
  logic                  empty_q, full_q;

  logic res_free, commit, accept;

  assign res_free = !out_valid_q || !out_stall_i;
  assign commit = stg_valid_q && res_free;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = stg_valid_q && !res_free;
  assign cfg_ready_o = 1'b1;

  // Evaluation of the staged operation.
  logic [MW-1:0] lim;
  logic          full_now, full_aft, used, empty_now;
  logic [CW-1:0] ftop_m1, pr, nx, n_ext, p_ext;
  logic [IW-1:0] new_n;
  logic          take, rel;
  logic          nwa, nwb, pwa, pwb;
  logic [CW-1:0] naddr_a, naddr_b, paddr_a, paddr_b;
  logic [CW-1:0] ndat_a, ndat_b, pdat_a, pdat_b;

  always_comb begin
    lim = (MW'(max_len_q) > NODES_M) ? NODES_M : MW'(max_len_q);
    full_now = (MW'(count_q) >= lim) || (free_top_q == '0);
    empty_now = (count_q == '0);
    used = used_q;
    pr = used_q ? pr_q : NIL;
    nx = used_q ? nx_q : NIL;
    ftop_m1 = free_top_q - CW'(1);
    new_n = new_n_q;
    n_ext = CW'(new_n);
    p_ext = CW'(pos_q);

    status_d = bdll_pkg::ST_OK;
    rpos_d = '0;
    relem_d = '0;
    take = 1'b0;
    rel = 1'b0;
    head_d = head_q;
    tail_d = tail_q;
    nwa = 1'b0; nwb = 1'b0; pwa = 1'b0; pwb = 1'b0;
    naddr_a = n_ext; naddr_b = n_ext; paddr_a = n_ext; paddr_b = n_ext;
    ndat_a = NIL; ndat_b = NIL; pdat_a = NIL; pdat_b = NIL;

    case (op_q)
      bdll_pkg::OP_APPEND, bdll_pkg::OP_INS_BEFORE, bdll_pkg::OP_INS_AFTER: begin
        if (full_now) begin
          status_d = bdll_pkg::ST_FULL;
        end else if ((op_q != bdll_pkg::OP_APPEND && !used) || val_q == '0) begin
          status_d = bdll_pkg::ST_BAD;
        end else begin
          take = 1'b1;
          rpos_d = new_n;
          nwa = 1'b1;
          pwa = 1'b1;
          if (op_q == bdll_pkg::OP_APPEND ||
              (op_q == bdll_pkg::OP_INS_AFTER && p_ext == tail_q)) begin
            // Append at the tail, also for insertion after the last node.
            ndat_a = NIL;
            pdat_a = tail_q;
            if (tail_q != NIL) begin
              nwb = 1'b1; naddr_b = tail_q; ndat_b = n_ext;
            end else begin
              head_d = n_ext;
            end
            tail_d = n_ext;
          end else if (op_q == bdll_pkg::OP_INS_BEFORE) begin
            ndat_a = p_ext;
            pdat_a = pr;
            pwb = 1'b1; paddr_b = p_ext; pdat_b = n_ext;
            if (pr != NIL) begin
              nwb = 1'b1; naddr_b = pr; ndat_b = n_ext;
            end else begin
              head_d = n_ext;
            end
          end else begin
            ndat_a = nx;
            pdat_a = p_ext;
            nwb = 1'b1; naddr_b = p_ext; ndat_b = n_ext;
            if (nx != NIL) begin
              pwb = 1'b1; paddr_b = nx; pdat_b = n_ext;
            end
          end
        end
      end
      bdll_pkg::OP_REMOVE: begin
        if (empty_now) begin
          status_d = bdll_pkg::ST_EMPTY;
        end else if (!used) begin
          status_d = bdll_pkg::ST_BAD;
        end else begin
          rel = 1'b1;
          rpos_d = pos_q;
          relem_d = rd_elem_q;
          nwa = 1'b1; naddr_a = p_ext; ndat_a = NIL;
          pwa = 1'b1; paddr_a = p_ext; pdat_a = NIL;
          if (pr != NIL) begin
            nwb = 1'b1; naddr_b = pr; ndat_b = nx;
          end else begin
            head_d = nx;
          end
          if (nx != NIL) begin
            pwb = 1'b1; paddr_b = nx; pdat_b = pr;
          end else begin
            tail_d = pr;
          end
        end
      end
      bdll_pkg::OP_READ: begin
        if (!used) begin
          status_d = bdll_pkg::ST_BAD;
        end else begin
          rpos_d = pos_q;
          relem_d = rd_elem_q;
        end
      end
      bdll_pkg::OP_FIRST, bdll_pkg::OP_LAST: begin
        if (empty_now) begin
          status_d = bdll_pkg::ST_EMPTY;
        end else begin
          rpos_d = (op_q == bdll_pkg::OP_FIRST) ? head_q[IW-1:0] : tail_q[IW-1:0];
        end
      end
      bdll_pkg::OP_NEXT, bdll_pkg::OP_PREV: begin
        if (empty_now) begin
          status_d = bdll_pkg::ST_EMPTY;
        end else if (!used) begin
          status_d = bdll_pkg::ST_BAD;
        end else if (((op_q == bdll_pkg::OP_NEXT) ? nx : pr) == NIL) begin
          status_d = bdll_pkg::ST_EMPTY;
        end else begin
          rpos_d = (op_q == bdll_pkg::OP_NEXT) ? nx[IW-1:0] : pr[IW-1:0];
        end
      end
      default: begin
        // Unknown operations change nothing and report success.
      end
    endcase

    count_d = count_q;
    free_top_d = free_top_q;
    if (take) begin
      count_d = count_q + CW'(1);
      free_top_d = ftop_m1;
    end else if (rel) begin
      count_d = count_q - CW'(1);
      if (free_top_q < NIL) begin
        free_top_d = free_top_q + CW'(1);
      end
    end
    full_aft = (MW'(count_d) >= lim) || (free_top_d == '0);
  end

  // Node state as the incoming beat will find it, with any write made by the
  // commit at the same edge taken in.
  logic [CW-1:0] nx_fw, pr_fw, ftop_fw;
  logic          used_fw;
  logic [IW-1:0] newn_fw;

  always_comb begin
    used_fw = (CW'(position_i) < NIL) && in_use_q[position_i];
    nx_fw = next_q[position_i];
    pr_fw = prev_q[position_i];
    ftop_fw = (commit ? free_top_d : free_top_q) - CW'(1);
    newn_fw = free_q[ftop_fw[IW-1:0]];
    if (commit) begin
      if (nwa && naddr_a == CW'(position_i)) nx_fw = ndat_a;
      if (nwb && naddr_b == CW'(position_i)) nx_fw = ndat_b;
      if (pwa && paddr_a == CW'(position_i)) pr_fw = pdat_a;
      if (pwb && paddr_b == CW'(position_i)) pr_fw = pdat_b;
      if (take && new_n == position_i) used_fw = 1'b1;
      if (rel && pos_q == position_i) used_fw = 1'b0;
      // A released node goes straight back on top of the free stack.
      if (rel && free_top_q < NIL) newn_fw = pos_q;
    end
  end

  // Node links, in-use flags and free stack.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        next_q[i] <= NIL;
        prev_q[i] <= NIL;
        free_q[i] <= IW'(NODES - 1 - i);
      end
      in_use_q <= '0;
      free_top_q <= NIL;
      head_q <= NIL;
      tail_q <= NIL;
      count_q <= '0;
    end else if (commit) begin
      for (int i = 0; i < NODES; i++) begin
        if (nwa && naddr_a == CW'(i)) next_q[i] <= ndat_a;
        if (nwb && naddr_b == CW'(i)) next_q[i] <= ndat_b;
        if (pwa && paddr_a == CW'(i)) prev_q[i] <= pdat_a;
        if (pwb && paddr_b == CW'(i)) prev_q[i] <= pdat_b;
      end
      if (take) begin
        in_use_q[new_n] <= 1'b1;
      end
      if (rel) begin
        in_use_q[pos_q] <= 1'b0;
        if (free_top_q < NIL) begin
          free_q[free_top_q[IW-1:0]] <= pos_q;
        end
      end
      free_top_q <= free_top_d;
      head_q <= head_d;
      tail_q <= tail_d;
      count_q <= count_d;
    end
  end

  // Element memory: one write port, one registered read port. A read of the
  // node being written in the same cycle takes the new element instead.
  always_ff @(posedge clk_i) begin
    if (commit && take) begin
      elem_mem[new_n] <= val_q;
    end
    if (accept) begin
      if (commit && take && new_n == position_i) begin
        rd_elem_q <= val_q;
      end else begin
        rd_elem_q <= elem_mem[position_i];
      end
    end
  end

  // Limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= bdll_pkg::MAX_LEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  // Stage and result control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        stg_valid_q <= 1'b1;
      end else if (commit) begin
        stg_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
      pos_q <= position_i;
      val_q <= elem_value_i;
      nx_q <= nx_fw;
      pr_q <= pr_fw;
      used_q <= used_fw;
      new_n_q <= newn_fw;
    end
    if (commit) begin
      status_q <= status_d;
      rpos_q <= rpos_d;
      relem_q <= relem_d;
      length_q <= count_d;
      empty_q <= (count_d == '0);
      full_q <= full_aft;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign result_position_o = rpos_q;
  assign result_elem_o = relem_q;
  assign length_o = length_q;
  assign is_empty_o = empty_q;
  assign is_full_o = full_q;

endmodule
`default_nettype wire

[sv/bdll_checker.sv]
// Port-level checker for the list manager, bound to its top level.
`default_nettype none
module bdll_checker #(
  parameter int unsigned NODES = 64,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [1:0]               status_o,
  input wire logic [$clog2(NODES)-1:0] result_position_o,
  input wire logic [ELEM_WIDTH-1:0]    result_elem_o,
  input wire logic [$clog2(NODES):0]   length_o,
  input wire logic                     is_empty_o
);

  localparam int unsigned CW = $clog2(NODES) + 1;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (length_o == '0)))
    else $error("empty flag disagrees with length");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != bdll_pkg::ST_OK |->
      result_position_o == '0 && result_elem_o == '0)
    else $error("failed operation reports data");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> length_o <= CW'(NODES))
    else $error("length beyond node count");

endmodule

bind bounded_doubly_linked_list_top bdll_checker #(
  .NODES(NODES), .ELEM_WIDTH(ELEM_WIDTH)
) u_bdll_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i), .status_o(status_o),
  .result_position_o(result_position_o), .result_elem_o(result_elem_o),
  .length_o(length_o), .is_empty_o(is_empty_o)
);
`default_nettype wire
